// ----- sv/ftpp_pkg.sv -----
// Shared types and constants of the file transfer packet parser.
`default_nettype none

package ftpp_pkg;

    // Parser states, one-hot.
    typedef enum logic [11:0] {
        ST_CTRL     = 12'b0000_0000_0001,
        ST_TYPE     = 12'b0000_0000_0010,
        ST_LEN      = 12'b0000_0000_0100,
        ST_VALUE    = 12'b0000_0000_1000,
        ST_SEQ      = 12'b0000_0001_0000,
        ST_LENHI    = 12'b0000_0010_0000,
        ST_LENLO    = 12'b0000_0100_0000,
        ST_RXDATA   = 12'b0000_1000_0000,
        ST_DATADONE = 12'b0001_0000_0000,
        ST_ENDOK    = 12'b0010_0000_0000,
        ST_STARTOK  = 12'b0100_0000_0000,
        ST_ERROR    = 12'b1000_0000_0000
    } t_state;

    // Status codes reported on the result channel.
    localparam logic [3:0] STS_CTRL     = 4'd0;
    localparam logic [3:0] STS_TYPE     = 4'd1;
    localparam logic [3:0] STS_LEN      = 4'd2;
    localparam logic [3:0] STS_VALUE    = 4'd3;
    localparam logic [3:0] STS_SEQ      = 4'd4;
    localparam logic [3:0] STS_LENHI    = 4'd5;
    localparam logic [3:0] STS_LENLO    = 4'd6;
    localparam logic [3:0] STS_RXDATA   = 4'd7;
    localparam logic [3:0] STS_DATADONE = 4'd8;
    localparam logic [3:0] STS_ENDOK    = 4'd9;
    localparam logic [3:0] STS_STARTOK  = 4'd10;
    localparam logic [3:0] STS_ERROR    = 4'd11;

    // Configuration register indexes.
    localparam logic [2:0] CFG_START_CODE = 3'd0;
    localparam logic [2:0] CFG_DATA_CODE  = 3'd1;
    localparam logic [2:0] CFG_END_CODE   = 3'd2;
    localparam logic [2:0] CFG_SIZE_TYPE  = 3'd3;
    localparam logic [2:0] CFG_NAME_TYPE  = 3'd4;

    // Sequence numbers run 0..254 and wrap.
    localparam logic [7:0] SEQ_MODULUS = 8'd255;
    localparam logic [7:0] SEQ_LAST    = 8'd254;

    // One access to the name store.
    typedef struct packed {
        logic       we;
        logic       re;
        logic [7:0] addr;
        logic [7:0] wdata;
    } t_ram_req;

    function automatic logic [3:0] state_code(input t_state s);
        logic [3:0] code;
        unique case (s)
            ST_CTRL:     code = STS_CTRL;
            ST_TYPE:     code = STS_TYPE;
            ST_LEN:      code = STS_LEN;
            ST_VALUE:    code = STS_VALUE;
            ST_SEQ:      code = STS_SEQ;
            ST_LENHI:    code = STS_LENHI;
            ST_LENLO:    code = STS_LENLO;
            ST_RXDATA:   code = STS_RXDATA;
            ST_DATADONE: code = STS_DATADONE;
            ST_ENDOK:    code = STS_ENDOK;
            ST_STARTOK:  code = STS_STARTOK;
            default:     code = STS_ERROR;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- sv/ftpp_name_ram.sv -----
// File name store: 256 x 8 synchronous memory, one access per cycle.
`default_nettype none

module ftpp_name_ram (
    input  wire logic              i_clk,
    input  wire ftpp_pkg::t_ram_req i_req,
    output logic [7:0]             o_rdata
);
    import ftpp_pkg::*;

    logic [7:0] mem [256];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            o_rdata <= mem[i_req.addr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/file_transfer_packet_parser.sv -----
// Top level of the file transfer packet parser.
//
// Input channel: one packet byte per word on i_data_byte, marked with
// i_packet_first and i_packet_last, handshaken by i_in_valid / o_in_ready.
// Output channel: one word per packet, after its last byte, carrying the
// parser status, the stored file size and the latest data payload length,
// handshaken by o_out_valid / i_out_ready.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (start, data and end codes, size and name TLV types); write only while idle.
// Throughput: one byte per cycle unless a result is blocked at the output. Each
// accepted byte is registered in a compare stage, which waits for the read of
// the name store that end packets compare against; a finished result then
// moves on to the output register that drives o_out_valid.
// A stalled receiver holds the output register; bytes keep flowing through
// the compare stage until a packet's last byte reaches it, then o_in_ready
// drops until the output drains.
// Reset (synchronous, active low) returns the parser to the control byte,
// clears stored size, name length, sequence count and data length, and
// loads the default codes. The name store itself is not cleared and needs
// no clearing pass: bytes are accepted as soon as reset is released.
`default_nettype none

module file_transfer_packet_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data,
    // input bytes
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_packet_first,
    input  wire logic        i_packet_last,
    // results
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [3:0]       o_parse_status,
    output logic [63:0]      o_file_size,
    output logic [15:0]      o_data_length
);
    import ftpp_pkg::*;

    // Configuration registers.
    logic [7:0] r_start_code, r_data_code, r_end_code, r_size_type, r_name_type;

    // Parser state.
    t_state      r_state, n_state;
    logic        r_fidx, n_fidx;       // 0: size field, 1: name field
    logic        r_endf, n_endf;       // parsing an end packet
    logic [15:0] r_ltot, n_ltot;
    logic [7:0]  r_lcnt, n_lcnt;
    logic [63:0] r_esize, n_esize;
    logic [63:0] r_ssize, n_ssize;
    logic [7:0]  r_nlen, n_nlen;
    logic        r_nm, n_nm;           // name mismatch seen so far
    logic [7:0]  r_seq, n_seq;
    logic [15:0] r_ldl, n_ldl;
    logic [8:0]  cnt_inc;
    logic [63:0] size_shift;

    // Compare stage.
    logic        r_p_vld, r_p_emit, r_p_cmp;
    logic [7:0]  r_p_byte;
    t_state      r_p_state;
    logic [63:0] r_p_size;
    logic [15:0] r_p_dlen;

    // Output register.
    logic        r_o_vld;
    logic [3:0]  r_o_status;
    logic [63:0] r_o_size;
    logic [15:0] r_o_dlen;

    t_ram_req    ram_req;
    logic [7:0]  ram_rdata;

    logic        acc, o_free, p_go, p_cmis, nm_cur;
    logic [3:0]  p_status;

    ftpp_name_ram u_name_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    // Handshake: the compare stage moves on unless it holds a result that
    // the full output register cannot take.
    assign o_free     = !r_o_vld || i_out_ready;
    assign p_go       = r_p_vld && (!r_p_emit || o_free);
    assign o_in_ready = !r_p_vld || p_go;
    assign acc        = i_in_valid && o_in_ready;

    // Name byte compare against the store read issued when the byte was accepted.
    assign p_cmis = r_p_cmp && (ram_rdata != r_p_byte);
    // An end packet that completed is only good if no name byte differed.
    assign p_status = (r_p_state == ST_ENDOK && (r_nm || p_cmis)) ?
                      STS_ERROR : state_code(r_p_state);
    // Fold this cycle's compare into the running mismatch flag.
    assign nm_cur = r_nm || (p_go && p_cmis);

    always_comb begin
        n_state  = r_state;
        n_fidx   = r_fidx;
        n_endf   = r_endf;
        n_ltot   = r_ltot;
        n_lcnt   = r_lcnt;
        n_esize  = r_esize;
        n_ssize  = r_ssize;
        n_nlen   = r_nlen;
        n_nm     = nm_cur;
        n_seq    = r_seq;
        n_ldl    = r_ldl;
        ram_req  = '0;
        cnt_inc  = '0;
        size_shift = '0;

        if (acc) begin
            // Clear per-packet state ahead of the first byte.
            if (i_packet_first) begin
                n_state = ST_CTRL;
                n_fidx  = 1'b0;
                n_endf  = 1'b0;
                n_ltot  = '0;
                n_lcnt  = '0;
                n_esize = '0;
                n_nm    = 1'b0;
            end
            ram_req.addr  = n_lcnt;
            ram_req.wdata = i_data_byte;
            cnt_inc       = {1'b0, n_lcnt} + 9'd1;

            unique case (n_state)
                ST_CTRL: begin
                    if (i_data_byte == r_start_code) begin
                        n_state = ST_TYPE;
                    end else if (i_data_byte == r_data_code) begin
                        n_state = ST_SEQ;
                    end else if (i_data_byte == r_end_code) begin
                        n_endf  = 1'b1;
                        n_state = ST_TYPE;
                    end else begin
                        n_state = ST_ERROR;
                    end
                end
                ST_TYPE: begin
                    if ((i_data_byte == r_size_type && !n_fidx) ||
                        (i_data_byte == r_name_type && n_fidx)) begin
                        if (!n_endf && !n_fidx) begin
                            n_ssize = '0;
                        end
                        n_state = ST_LEN;
                    end else begin
                        n_state = ST_ERROR;
                    end
                end
                ST_LEN: begin
                    n_ltot = {8'h00, i_data_byte};
                    n_lcnt = '0;
                    if (n_fidx) begin
                        if (n_endf) begin
                            if (i_data_byte != r_nlen) begin
                                n_nm = 1'b1;
                            end
                        end else begin
                            n_nlen = i_data_byte;
                        end
                    end
                    n_state = ST_VALUE;
                end
                ST_VALUE: begin
                    if ({8'h00, n_lcnt} >= n_ltot) begin
                        n_state = ST_ERROR;
                    end else if (!n_fidx) begin
                        // Shift the size in big-endian, wrapping at 64 bits.
                        size_shift = {(n_endf ? n_esize[55:0] : n_ssize[55:0]), i_data_byte};
                        if (n_endf) begin
                            n_esize = size_shift;
                        end else begin
                            n_ssize = size_shift;
                        end
                        n_lcnt = cnt_inc[7:0];
                        if ({7'd0, cnt_inc} == n_ltot) begin
                            if (n_endf && size_shift != r_ssize) begin
                                n_state = ST_ERROR;
                            end else begin
                                n_state = ST_TYPE;
                                n_fidx  = 1'b1;
                            end
                        end
                    end else begin
                        // Name byte: store it, or read it back for compare.
                        ram_req.re = n_endf;
                        ram_req.we = !n_endf;
                        n_lcnt     = cnt_inc[7:0];
                        if ({7'd0, cnt_inc} == n_ltot) begin
                            n_state = n_endf ? ST_ENDOK : ST_STARTOK;
                        end
                    end
                end
                ST_SEQ: begin
                    if (i_data_byte < SEQ_MODULUS && i_data_byte == r_seq) begin
                        n_seq   = (r_seq == SEQ_LAST) ? 8'd0 : r_seq + 8'd1;
                        n_state = ST_LENHI;
                    end else begin
                        n_state = ST_ERROR;
                    end
                end
                ST_LENHI: begin
                    n_ltot  = {i_data_byte, 8'h00};
                    n_state = ST_LENLO;
                end
                ST_LENLO: begin
                    n_ltot  = n_ltot | {8'h00, i_data_byte};
                    n_lcnt  = '0;
                    n_state = ST_RXDATA;
                end
                ST_RXDATA: begin
                    n_ldl   = n_ltot;
                    n_state = ST_DATADONE;
                end
                default: begin
                    // Terminal states: drop bytes until the next packet.
                end
            endcase
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_code <= 8'd2;
            r_data_code  <= 8'd1;
            r_end_code   <= 8'd3;
            r_size_type  <= 8'd0;
            r_name_type  <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_CODE: r_start_code <= i_cfg_data;
                CFG_DATA_CODE:  r_data_code  <= i_cfg_data;
                CFG_END_CODE:   r_end_code   <= i_cfg_data;
                CFG_SIZE_TYPE:  r_size_type  <= i_cfg_data;
                CFG_NAME_TYPE:  r_name_type  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CTRL;
            r_fidx  <= 1'b0;
            r_endf  <= 1'b0;
            r_ltot  <= '0;
            r_lcnt  <= '0;
            r_esize <= '0;
            r_ssize <= '0;
            r_nlen  <= '0;
            r_nm    <= 1'b0;
            r_seq   <= '0;
            r_ldl   <= '0;
        end else begin
            r_state <= n_state;
            r_fidx  <= n_fidx;
            r_endf  <= n_endf;
            r_ltot  <= n_ltot;
            r_lcnt  <= n_lcnt;
            r_esize <= n_esize;
            r_ssize <= n_ssize;
            r_nlen  <= n_nlen;
            r_nm    <= n_nm;
            r_seq   <= n_seq;
            r_ldl   <= n_ldl;
        end
    end

    // Compare stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld  <= 1'b0;
            r_p_emit <= 1'b0;
            r_p_cmp  <= 1'b0;
        end else if (acc) begin
            r_p_vld  <= 1'b1;
            r_p_emit <= i_packet_last;
            r_p_cmp  <= ram_req.re;
        end else if (p_go) begin
            r_p_vld  <= 1'b0;
        end
    end

    // Compare stage payload.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_p_byte  <= i_data_byte;
            r_p_state <= n_state;
            r_p_size  <= n_ssize;
            r_p_dlen  <= n_ldl;
        end
    end

    // Output register: load a finished result, hold while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (p_go && r_p_emit) begin
            r_o_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_go && r_p_emit) begin
            r_o_status <= p_status;
            r_o_size   <= r_p_size;
            r_o_dlen   <= r_p_dlen;
        end
    end

    assign o_out_valid    = r_o_vld;
    assign o_parse_status = r_o_status;
    assign o_file_size    = r_o_size;
    assign o_data_length  = r_o_dlen;

`ifndef SYNTHESIS
    a_ram_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_req.we && ram_req.re))
        else $error("name store written and read in one cycle");

    a_stall_from_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_p_vld && r_p_emit && r_o_vld && !i_out_ready))
        else $error("input stalled without a blocked result");

    a_first_clears_mismatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_packet_first) |=> !r_nm)
        else $error("name mismatch survived a new packet");
`endif

endmodule

`default_nettype wire
